// File: rtl/mfab_pkg.sv
// Shared types and constants for the augmenting-path maximum flow block.
`timescale 1ns / 1ps
`default_nettype none

package mfab_pkg;

    localparam int VERTEX_W = 8;
    localparam int CAP_W    = 31;
    localparam int FLOW_W   = 41;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'd1;

    localparam logic [VERTEX_W-1:0] SOURCE_RESET = 8'd0;
    localparam logic [VERTEX_W-1:0] SINK_RESET   = 8'd127;

    // One input transaction: a directed edge.
    typedef struct packed {
        logic [VERTEX_W-1:0] edge_tail;
        logic [VERTEX_W-1:0] edge_head;
        logic [CAP_W-1:0]    edge_capacity;
        logic                last_edge;
    } t_edge_item;

    // One result transaction.
    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic              edges_dropped;
    } t_flow_result;

    // Stored edge record.
    typedef struct packed {
        logic [VERTEX_W-1:0] tail;
        logic [VERTEX_W-1:0] head;
        logic [CAP_W-1:0]    cap;
    } t_edge_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_ARC_RD,
        S_EDGE_RD,
        S_EVAL,
        S_FINISH
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic init;
        logic rescan;
        logic scan_issue;
        logic path_start;
        logic flow_start;
        logic edge_rd;
        logic eval;
        logic add_total;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic last_edge;
        logic cfg_ok;
        logic count_zero;
        logic scan_last;
        logic changed;
        logic sink_marked;
        logic at_src;
        logic pass_two;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/mfab_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mfab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/mfab_ctrl.sv
// Controller state machine for load, residual sweeps and path augmentation.
`timescale 1ns / 1ps
`default_nettype none

module mfab_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mfab_pkg::t_dp_stat i_stat,
    output mfab_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy
);

    mfab_pkg::t_state r_state;
    mfab_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfab_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfab_pkg::S_IDLE: begin
                if (i_start && i_stat.last_edge) begin
                    n_state = i_stat.cfg_ok ? mfab_pkg::S_INIT : mfab_pkg::S_FINISH;
                end
            end
            mfab_pkg::S_INIT: begin
                n_state = i_stat.count_zero ? mfab_pkg::S_DECIDE : mfab_pkg::S_SCAN;
            end
            mfab_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = mfab_pkg::S_SCAN_END;
                end
            end
            mfab_pkg::S_SCAN_END: n_state = mfab_pkg::S_DECIDE;
            mfab_pkg::S_DECIDE: begin
                if (i_stat.sink_marked) begin
                    n_state = mfab_pkg::S_ARC_RD;
                end else if (i_stat.changed) begin
                    n_state = mfab_pkg::S_SCAN;
                end else begin
                    n_state = mfab_pkg::S_FINISH;
                end
            end
            mfab_pkg::S_ARC_RD:  n_state = mfab_pkg::S_EDGE_RD;
            mfab_pkg::S_EDGE_RD: n_state = mfab_pkg::S_EVAL;
            mfab_pkg::S_EVAL: begin
                if (i_stat.at_src && i_stat.pass_two) begin
                    n_state = mfab_pkg::S_INIT;
                end else begin
                    n_state = mfab_pkg::S_ARC_RD;
                end
            end
            mfab_pkg::S_FINISH: n_state = mfab_pkg::S_IDLE;
            default: n_state = mfab_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != mfab_pkg::S_IDLE);
        case (r_state)
            mfab_pkg::S_IDLE:     o_cmd.load = i_start;
            mfab_pkg::S_INIT:     o_cmd.init = 1'b1;
            mfab_pkg::S_SCAN:     o_cmd.scan_issue = 1'b1;
            mfab_pkg::S_SCAN_END: o_cmd = '0;
            mfab_pkg::S_DECIDE: begin
                if (i_stat.sink_marked) begin
                    o_cmd.path_start = 1'b1;
                end else if (i_stat.changed) begin
                    o_cmd.rescan = 1'b1;
                end
            end
            mfab_pkg::S_ARC_RD:  o_cmd = '0;
            mfab_pkg::S_EDGE_RD: o_cmd.edge_rd = 1'b1;
            mfab_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.at_src) begin
                    o_cmd.flow_start = !i_stat.pass_two;
                    o_cmd.add_total  = i_stat.pass_two;
                end
            end
            mfab_pkg::S_FINISH: o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mfab_dp.sv
// Datapath: edge and flow memories, visited marks, arc table and flow sums.
`timescale 1ns / 1ps
`default_nettype none

module mfab_dp #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [mfab_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [mfab_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  wire mfab_pkg::t_edge_item                    i_edge,
    input  wire mfab_pkg::t_dp_cmd                       i_cmd,
    output mfab_pkg::t_dp_stat                           o_stat,
    output logic                                         o_result_valid,
    output mfab_pkg::t_flow_result                       o_result
);

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int ARC_W = EAW + 1;
    localparam int REC_W = $bits(mfab_pkg::t_edge_rec);

    logic [mfab_pkg::VERTEX_W-1:0] r_src;
    logic [mfab_pkg::VERTEX_W-1:0] r_snk;
    logic [ECW-1:0]                r_edge_count;
    logic                          r_overflow;
    logic [MAX_VERTICES-1:0]       r_marks;
    logic [MAX_VERTICES-1:0]       r_marks_prev;
    logic                          r_changed;
    logic [EAW-1:0]                r_scan_addr;
    logic [EAW-1:0]                r_scan_addr_d;
    logic                          r_scan_vld;
    logic [mfab_pkg::VERTEX_W-1:0] r_cur;
    logic                          r_pass_two;
    logic [mfab_pkg::CAP_W-1:0]    r_delta;
    logic [mfab_pkg::FLOW_W-1:0]   r_total;
    logic [ARC_W-1:0]              r_arc;

    logic                          edge_ok;
    logic                          load_we;
    mfab_pkg::t_edge_rec           rec_wdata;
    mfab_pkg::t_edge_rec           rec_rdata;
    logic [REC_W-1:0]              rec_rbits;
    logic [EAW-1:0]                edge_raddr;
    logic [EAW-1:0]                load_addr;
    logic [mfab_pkg::CAP_W-1:0]    flow_rdata;
    logic                          flow_we;
    logic [EAW-1:0]                flow_waddr;
    logic [mfab_pkg::CAP_W-1:0]    flow_wdata;
    logic [ARC_W-1:0]              arc_rdata;
    logic                          arc_we;
    logic [VAW-1:0]                arc_waddr;
    logic [ARC_W-1:0]              arc_wdata;
    logic [VAW-1:0]                tail_a;
    logic [VAW-1:0]                head_a;
    logic                          mark_t;
    logic                          mark_h;
    logic                          seed_t;
    logic                          seed_h;
    logic                          fwd;
    logic                          bwd;
    logic                          arc_dir;
    logic [mfab_pkg::CAP_W-1:0]    resid;
    logic [mfab_pkg::CAP_W-1:0]    flow_new;
    logic [mfab_pkg::VERTEX_W-1:0] next_cur;
    logic [mfab_pkg::FLOW_W:0]     sum;

    // Load-side checks.
    assign edge_ok = (32'(i_edge.edge_tail) < MAX_VERTICES)
                  && (32'(i_edge.edge_head) < MAX_VERTICES)
                  && (r_edge_count < ECW'(MAX_EDGES));
    assign load_we   = i_cmd.load && edge_ok;
    assign load_addr = EAW'(r_edge_count);
    assign rec_wdata = '{tail: i_edge.edge_tail, head: i_edge.edge_head,
                         cap: i_edge.edge_capacity};

    // Edge reads come from the sweep or from the traced arc.
    assign edge_raddr = i_cmd.edge_rd ? arc_rdata[ARC_W-1:1] : r_scan_addr;
    assign rec_rdata  = mfab_pkg::t_edge_rec'(rec_rbits);

    mfab_ram #(.WIDTH(REC_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(load_addr),
        .i_wdata(rec_wdata),
        .i_raddr(edge_raddr),
        .o_rdata(rec_rbits)
    );

    // Flow memory: cleared per edge at load, updated on augmentation.
    assign arc_dir  = r_arc[0];
    assign resid    = arc_dir ? flow_rdata : (rec_rdata.cap - flow_rdata);
    assign flow_new = arc_dir ? (flow_rdata - r_delta) : (flow_rdata + r_delta);
    assign flow_we    = load_we || (i_cmd.eval && r_pass_two);
    assign flow_waddr = i_cmd.load ? load_addr : r_arc[ARC_W-1:1];
    assign flow_wdata = i_cmd.load ? '0 : flow_new;

    mfab_ram #(.WIDTH(mfab_pkg::CAP_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_flow_ram (
        .i_clk  (i_clk),
        .i_we   (flow_we),
        .i_waddr(flow_waddr),
        .i_wdata(flow_wdata),
        .i_raddr(edge_raddr),
        .o_rdata(flow_rdata)
    );

    // Sweep evaluation of one residual edge in each direction. Only vertices
    // reached before the sweep began can extend the search, so each sweep adds
    // exactly one breadth-first layer and a found path is a shortest one.
    assign tail_a = VAW'(rec_rdata.tail);
    assign head_a = VAW'(rec_rdata.head);
    assign mark_t = r_marks[tail_a];
    assign mark_h = r_marks[head_a];
    assign seed_t = r_marks_prev[tail_a];
    assign seed_h = r_marks_prev[head_a];
    assign fwd = r_scan_vld && seed_t && !mark_h && (rec_rdata.cap != flow_rdata);
    assign bwd = r_scan_vld && seed_h && !mark_t && (flow_rdata != '0);
    assign arc_we    = fwd || bwd;
    assign arc_waddr = fwd ? head_a : tail_a;
    assign arc_wdata = {r_scan_addr_d, bwd};

    mfab_ram #(.WIDTH(ARC_W), .DEPTH(MAX_VERTICES), .AW(VAW)) u_arc_ram (
        .i_clk  (i_clk),
        .i_we   (arc_we),
        .i_waddr(arc_waddr),
        .i_wdata(arc_wdata),
        .i_raddr(VAW'(r_cur)),
        .o_rdata(arc_rdata)
    );

    assign next_cur = arc_dir ? rec_rdata.head : rec_rdata.tail;
    assign sum      = {1'b0, r_total} + (mfab_pkg::FLOW_W + 1)'(r_delta);

    // Status back to the controller.
    always_comb begin
        o_stat.last_edge   = i_edge.last_edge;
        o_stat.cfg_ok      = (r_src != r_snk) && (32'(r_src) < MAX_VERTICES)
                          && (32'(r_snk) < MAX_VERTICES);
        o_stat.count_zero  = (r_edge_count == '0);
        o_stat.scan_last   = (r_scan_addr == EAW'(r_edge_count - ECW'(1)));
        o_stat.changed     = r_changed;
        o_stat.sink_marked = r_marks[VAW'(r_snk)];
        o_stat.at_src      = (next_cur == r_src);
        o_stat.pass_two    = r_pass_two;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src          <= mfab_pkg::SOURCE_RESET;
            r_snk          <= mfab_pkg::SINK_RESET;
            r_edge_count   <= '0;
            r_overflow     <= 1'b0;
            r_marks        <= '0;
            r_marks_prev   <= '0;
            r_changed      <= 1'b0;
            r_scan_vld     <= 1'b0;
            r_pass_two     <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == mfab_pkg::CFG_SOURCE)) begin
                r_src <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == mfab_pkg::CFG_SINK)) begin
                r_snk <= i_cfg_wdata;
            end
            if (load_we) begin
                r_edge_count <= r_edge_count + ECW'(1);
            end else if (i_cmd.load) begin
                r_overflow <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_edge_count <= '0;
                r_overflow   <= 1'b0;
            end
            r_scan_vld <= i_cmd.scan_issue;
            if (i_cmd.init) begin
                r_marks      <= MAX_VERTICES'(1) << VAW'(r_src);
                r_marks_prev <= MAX_VERTICES'(1) << VAW'(r_src);
                r_changed    <= 1'b0;
            end else if (i_cmd.rescan) begin
                r_marks_prev <= r_marks;
                r_changed    <= 1'b0;
            end else if (arc_we) begin
                r_marks[arc_waddr] <= 1'b1;
                r_changed          <= 1'b1;
            end
            if (i_cmd.path_start) begin
                r_pass_two <= 1'b0;
            end else if (i_cmd.flow_start) begin
                r_pass_two <= 1'b1;
            end
            o_result_valid <= i_cmd.finish;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_scan_addr_d <= r_scan_addr;
        if (i_cmd.init || i_cmd.rescan) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_addr <= r_scan_addr + EAW'(1);
        end
        if (i_cmd.edge_rd) begin
            r_arc <= arc_rdata;
        end
        if (i_cmd.path_start) begin
            r_cur   <= r_snk;
            r_delta <= '1;
        end else if (i_cmd.flow_start) begin
            // The hop that reaches the source still counts toward the bottleneck.
            r_cur <= r_snk;
            if (resid < r_delta) begin
                r_delta <= resid;
            end
        end else if (i_cmd.eval) begin
            r_cur <= next_cur;
            if (!r_pass_two && (resid < r_delta)) begin
                r_delta <= resid;
            end
        end
        if (i_cmd.load && i_edge.last_edge) begin
            r_total <= '0;
        end else if (i_cmd.add_total) begin
            r_total <= sum[mfab_pkg::FLOW_W] ? '1 : sum[mfab_pkg::FLOW_W-1:0];
        end
        if (i_cmd.finish) begin
            o_result.max_flow      <= r_total;
            o_result.edges_dropped <= r_overflow;
        end
    end

endmodule

`default_nettype wire

// File: rtl/max_flow_augmenting_bfs.sv
// Top level of the augmenting-path maximum flow block.
//
// Usage: each input transaction is one directed edge, taken at a clock edge
// where i_start is high and o_busy is low, so edges can be taken back to back.
// Edges with an endpoint out of range or beyond the edge memory are dropped
// and reported in edges_dropped. The transaction with last_edge set is stored
// too and starts the computation; o_busy stays high until it ends.
// The computation repeats label sweeps over the stored edges (one edge read
// per cycle from the edge and flow memories), each sweep adding one
// breadth-first layer, until the sink is reached or no label changes; a found
// path is then walked twice from the sink back to the source, each hop
// passing through arc read, edge read and evaluate states, to take its
// bottleneck and push it. The run ends when a search fails.
// The result transaction appears on o_result for exactly one cycle, marked by
// o_result_valid, in the first cycle in which o_busy is low again; the
// receiver cannot stall it.
// Configuration (source and sink) is written through i_cfg_we by the user only
// while idle; the block does not enforce this. Synchronous reset clears control
// state, edge count and visited marks; memories are not cleared and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module max_flow_augmenting_bfs #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mfab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mfab_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_start,
    input  wire mfab_pkg::t_edge_item            i_edge,
    output logic                                 o_busy,
    output logic                                 o_result_valid,
    output mfab_pkg::t_flow_result               o_result
);

    mfab_pkg::t_dp_cmd  cmd;
    mfab_pkg::t_dp_stat stat;
    logic               start_ok;

    // A new transaction is taken only while the block is idle.
    assign start_ok = i_start && !o_busy;

    mfab_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start_ok),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    mfab_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_edge        (i_edge),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the augmenting-path maximum flow block.
`timescale 1ns / 1ps

module tb_top;

    localparam int VW = mfab_pkg::VERTEX_W;
    localparam int CW = mfab_pkg::CAP_W;
    localparam int FW = mfab_pkg::FLOW_W;
    localparam int NUM_VERTICES = 256;
    localparam int EDGE_DEPTH   = 1024;
    localparam int WATCHDOG_MAX = 4000000;
    localparam int RANDOM_EDGES = 850;
    localparam logic [CW-1:0] CAP_FULL = {CW{1'b1}};

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [mfab_pkg::CFG_IDX_W-1:0]  i_cfg_idx = mfab_pkg::CFG_SOURCE;
    logic [mfab_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic           i_start = 1'b0;
    mfab_pkg::t_edge_item   i_edge = '0;
    logic           o_busy;
    logic           o_result_valid;
    mfab_pkg::t_flow_result o_result;

    max_flow_augmenting_bfs dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .i_edge         (i_edge),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the block's configuration and edge memory.
    logic [VW-1:0] src_vertex = mfab_pkg::SOURCE_RESET;
    logic [VW-1:0] snk_vertex = mfab_pkg::SINK_RESET;
    logic [VW-1:0] graph_tail [EDGE_DEPTH];
    logic [VW-1:0] graph_head [EDGE_DEPTH];
    logic [CW-1:0] graph_cap  [EDGE_DEPTH];
    int            graph_edges = 0;
    logic          graph_dropped = 1'b0;

    mfab_pkg::t_flow_result expected_flows [$];
    int           num_errors = 0;
    int           num_edges = 0;
    int           num_results = 0;
    int           num_dropped_graphs = 0;
    int           idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        num_errors++;
    endtask

    // Shortest augmenting paths over the shadow graph.
    function automatic logic [FW-1:0] solve_max_flow();
        logic [CW-1:0] flow [EDGE_DEPTH];
        int            via_arc [NUM_VERTICES];
        int            prev [NUM_VERTICES];
        bit            seen [NUM_VERTICES];
        int            bfs_q [NUM_VERTICES];
        int            qh, qt, u, w, e, cur;
        logic [CW-1:0] bottleneck, res;
        logic [FW-1:0] total;
        total = '0;
        if (src_vertex == snk_vertex) return '0;
        for (e = 0; e < graph_edges; e++) flow[e] = '0;
        forever begin
            for (w = 0; w < NUM_VERTICES; w++) seen[w] = 0;
            seen[src_vertex] = 1;
            qh = 0;
            qt = 1;
            bfs_q[0] = int'(src_vertex);
            while (qh < qt && !seen[snk_vertex]) begin
                u = bfs_q[qh++];
                for (e = 0; e < graph_edges; e++) begin
                    if (graph_tail[e] == graph_head[e]) continue;
                    if (int'(graph_tail[e]) == u && graph_cap[e] != flow[e]
                            && !seen[graph_head[e]]) begin
                        w = int'(graph_head[e]);
                        via_arc[w] = 2 * e;
                    end else if (int'(graph_head[e]) == u && flow[e] != 0
                            && !seen[graph_tail[e]]) begin
                        w = int'(graph_tail[e]);
                        via_arc[w] = 2 * e + 1;
                    end else begin
                        continue;
                    end
                    seen[w] = 1;
                    prev[w] = u;
                    bfs_q[qt++] = w;
                end
            end
            if (!seen[snk_vertex]) return total;
            bottleneck = CAP_FULL;
            for (cur = int'(snk_vertex); cur != int'(src_vertex); cur = prev[cur]) begin
                e = via_arc[cur] / 2;
                res = via_arc[cur][0] ? flow[e] : graph_cap[e] - flow[e];
                if (res < bottleneck) bottleneck = res;
            end
            for (cur = int'(snk_vertex); cur != int'(src_vertex); cur = prev[cur]) begin
                e = via_arc[cur] / 2;
                if (via_arc[cur][0]) flow[e] -= bottleneck;
                else flow[e] += bottleneck;
            end
            total = total + FW'(bottleneck);
        end
    endfunction

    // Track one accepted edge transaction and queue the flow it causes.
    task automatic record_edge(input mfab_pkg::t_edge_item it);
        mfab_pkg::t_flow_result outcome;
        if (graph_edges < EDGE_DEPTH) begin
            graph_tail[graph_edges] = it.edge_tail;
            graph_head[graph_edges] = it.edge_head;
            graph_cap[graph_edges]  = it.edge_capacity;
            graph_edges++;
        end else begin
            graph_dropped = 1'b1;
        end
        num_edges++;
        if (it.last_edge) begin
            outcome.max_flow      = solve_max_flow();
            outcome.edges_dropped = graph_dropped;
            if (graph_dropped) num_dropped_graphs++;
            expected_flows.push_back(outcome);
            graph_edges   = 0;
            graph_dropped = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Send one edge transaction; start stays high into the next one unless idling.
    task automatic send_edge(input mfab_pkg::t_edge_item it, input int gap);
        bit accepted;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_edge  <= it;
        accepted = 0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !o_busy;
        end
        record_edge(it);
    endtask

    task automatic send_plain(input int tail, input int head, input logic [CW-1:0] cap,
                              input bit last);
        mfab_pkg::t_edge_item it;
        it.edge_tail     = VW'(tail);
        it.edge_head     = VW'(head);
        it.edge_capacity = cap;
        it.last_edge     = last;
        send_edge(it, pick_gap());
    endtask

    // Wait until every flow has come back and the block has settled.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_flows.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [mfab_pkg::CFG_IDX_W-1:0] idx,
                             input logic [VW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == mfab_pkg::CFG_SOURCE) src_vertex = val;
        else snk_vertex = val;
    endtask

    task automatic set_terminals(input int src, input int snk);
        wait_idle();
        write_cfg(mfab_pkg::CFG_SOURCE, VW'(src));
        write_cfg(mfab_pkg::CFG_SINK, VW'(snk));
    endtask

    // Reset values of source and sink, including the classic reverse-arc graph.
    task automatic test_reset_terminals();
        send_plain(0, 127, CAP_FULL, 1);
        send_plain(0, 1, 1, 0);
        send_plain(0, 2, 1, 0);
        send_plain(1, 2, 1, 0);
        send_plain(1, 127, 1, 0);
        send_plain(2, 127, 1, 1);
    endtask

    // Extremes, self loops, parallel edges, zero capacity, and source equal to sink.
    task automatic test_special_cases();
        set_terminals(255, 0);
        send_plain(255, 255, 77, 0);
        send_plain(255, 0, CAP_FULL, 0);
        send_plain(255, 0, CAP_FULL, 0);
        send_plain(255, 0, 0, 0);
        send_plain(0, 255, 5, 1);
        set_terminals(9, 9);
        send_plain(9, 3, 10, 0);
        send_plain(3, 9, 10, 1);
        set_terminals(0, 255);
        send_plain(0, 128, 31'h5555_5555, 0);
        send_plain(128, 255, 31'h2AAA_AAAA, 0);
        send_plain(0, 255, 0, 1);
        send_plain(0, 255, 0, 1);
    endtask

    // More edges than the memory holds: the extra ones are dropped and flagged.
    task automatic test_edge_overflow();
        int k;
        set_terminals(4, 5);
        send_plain(4, 5, 1000, 0);
        for (k = 1; k < EDGE_DEPTH + 6; k++) send_plain(200, 200, CW'(k), 0);
        send_plain(4, 5, 1, 1);
        set_terminals(4, 5);
        send_plain(4, 5, 3, 1);
    endtask

    function automatic logic [CW-1:0] pick_capacity();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CAP_FULL;
            2, 3: return CW'($urandom()) & CAP_FULL;
            default: return CW'($urandom_range(1, 20));
        endcase
    endfunction

    // Random small graphs around the terminals under random configurations.
    task automatic test_random_graphs();
        int pool [8];
        int n, k, sent, roll;
        sent = 0;
        while (sent < RANDOM_EDGES) begin
            roll = $urandom_range(0, 9);
            if (roll < 2) set_terminals(roll == 0 ? 0 : 255, roll == 0 ? 255 : 0);
            else if (roll < 8) set_terminals($urandom_range(0, 255), $urandom_range(0, 255));
            pool[0] = int'(src_vertex);
            pool[1] = int'(snk_vertex);
            for (k = 2; k < 8; k++) pool[k] = $urandom_range(0, 255);
            n = $urandom_range(1, 14);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) < 8)
                    send_plain(pool[$urandom_range(0, 7)], pool[$urandom_range(0, 7)],
                               pick_capacity(), k == n - 1);
                else
                    send_plain($urandom_range(0, 255), $urandom_range(0, 255),
                               pick_capacity(), k == n - 1);
                sent++;
            end
        end
    endtask

    // Compare each flow result with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            num_results++;
            if (expected_flows.size() == 0) begin
                report_mismatch("flow result with none expected");
            end else begin
                if (o_result.max_flow !== expected_flows[0].max_flow)
                    report_mismatch($sformatf("max_flow got %0d expected %0d",
                        o_result.max_flow, expected_flows[0].max_flow));
                if (o_result.edges_dropped !== expected_flows[0].edges_dropped)
                    report_mismatch($sformatf("edges_dropped got %0b expected %0b",
                        o_result.edges_dropped, expected_flows[0].edges_dropped));
                void'(expected_flows.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Timeout with %0d flows outstanding", expected_flows.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_terminals();
        test_special_cases();
        test_edge_overflow();
        test_random_graphs();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (expected_flows.size() != 0) report_mismatch("flow results never arrived");
        $display("Covered %0d edge transactions and %0d flow results,", num_edges, num_results);
        $display("%0d graphs with dropped edges, %0d mismatches.", num_dropped_graphs,
                 num_errors);
        if (num_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
